// ===== rtl/core/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

// ===== rtl/core/oaht_pkg.sv =====
package oaht_pkg;

   localparam int DEF_TABLE_SLOTS = 256;
   localparam logic [7:0] LOAD_LIMIT_RESET = 8'd192;

   localparam logic [1:0] OP_GET    = 2'd0;
   localparam logic [1:0] OP_SET    = 2'd1;
   localparam logic [1:0] OP_DELETE = 2'd2;

   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_MISS = 2'd1;
   localparam logic [1:0] STATUS_FULL = 2'd2;

   localparam logic [1:0] KIND_EMPTY = 2'd0;
   localparam logic [1:0] KIND_USED  = 2'd1;
   localparam logic [1:0] KIND_TOMB  = 2'd2;

   localparam logic CSR_IDX_LOAD_LIMIT = 1'b0;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PROBE
   } state_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] key;
      logic [63:0] value;
   } slot_type;

endpackage

// ===== rtl/core/oaht_slot_ram.sv =====
module oaht_slot_ram #(
   parameter int TABLE_SLOTS = oaht_pkg::DEF_TABLE_SLOTS
) (
   input  logic                           clock,
   input  logic                           we,
   input  logic [$clog2(TABLE_SLOTS)-1:0] waddr,
   input  oaht_pkg::slot_type             wdata,
   input  logic [$clog2(TABLE_SLOTS)-1:0] raddr,
   output oaht_pkg::slot_type             rdata
);

   oaht_pkg::slot_type slot_mem [TABLE_SLOTS];
   oaht_pkg::slot_type rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         slot_mem[waddr] <= wdata;
      end
      rdata_ff <= slot_mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/core/oaht_csr.sv =====
module oaht_csr (
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready,
   output logic [7:0]  load_limit
);

   logic [7:0] load_limit_ff;
   logic [7:0] load_limit_in;
   logic       wr_hit;

   assign pready = 1'b1;
   assign wr_hit = psel && penable && pwrite && (paddr[2] == oaht_pkg::CSR_IDX_LOAD_LIMIT);

   always_comb begin
      load_limit_in = load_limit_ff;
      if (wr_hit) begin
         load_limit_in = pwdata[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_limit_ff <= oaht_pkg::LOAD_LIMIT_RESET;
      end else begin
         load_limit_ff <= load_limit_in;
      end
   end

   assign prdata = (paddr[2] == oaht_pkg::CSR_IDX_LOAD_LIMIT) ? {24'd0, load_limit_ff} : 32'd0;
   assign load_limit = load_limit_ff;

endmodule

// ===== rtl/core/oaht_probe.sv =====
`include "assert_macros.svh"

module oaht_probe #(
   parameter int TABLE_SLOTS = oaht_pkg::DEF_TABLE_SLOTS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [1:0]                     req_op,
   input  logic [31:0]                    req_key_id,
   input  logic [31:0]                    req_key_hash,
   input  logic [63:0]                    req_write_value,
   output logic                           rsp_valid,
   output logic [1:0]                     rsp_status,
   output logic                           rsp_is_new_key,
   output logic [63:0]                    rsp_read_value,
   input  logic [7:0]                     load_limit,
   output logic                           mem_we,
   output logic [$clog2(TABLE_SLOTS)-1:0] mem_waddr,
   output oaht_pkg::slot_type             mem_wdata,
   output logic [$clog2(TABLE_SLOTS)-1:0] mem_raddr,
   input  oaht_pkg::slot_type             mem_rdata
);

   localparam int AW = $clog2(TABLE_SLOTS);

   oaht_pkg::state_type state_ff, state_in;

   logic [AW-1:0] clr_idx_ff, clr_idx_in;
   logic [AW-1:0] rd_idx_ff, rd_idx_in;
   logic [AW-1:0] count_ff, count_in;
   logic [AW-1:0] tomb_idx_ff, tomb_idx_in;
   logic          tomb_seen_ff, tomb_seen_in;
   logic [8:0]    used_count_ff, used_count_in;
   logic [1:0]    op_ff, op_in;
   logic [31:0]   key_ff, key_in;
   logic [63:0]   wval_ff, wval_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    rsp_status_ff, rsp_status_in;
   logic          rsp_new_ff, rsp_new_in;
   logic [63:0]   rsp_value_ff, rsp_value_in;

   logic          accept;
   logic          early_miss;
   logic          cur_used;
   logic          cur_tomb;
   logic          cur_empty;
   logic          hit;
   logic          probe_done;
   logic          tomb_any;
   logic [AW-1:0] tomb_at;
   logic [AW-1:0] target;
   logic          fresh;
   logic          none;
   logic          over;

   assign busy   = (state_ff != oaht_pkg::ST_IDLE);
   assign accept = start && (state_ff == oaht_pkg::ST_IDLE);
   assign early_miss = (req_op != oaht_pkg::OP_SET) &&
                       (((req_op != oaht_pkg::OP_GET) && (req_op != oaht_pkg::OP_DELETE)) ||
                        (used_count_ff == 9'd0));

   assign cur_used   = (mem_rdata.kind == oaht_pkg::KIND_USED);
   assign cur_tomb   = (mem_rdata.kind == oaht_pkg::KIND_TOMB);
   assign cur_empty  = !cur_used && !cur_tomb;
   assign hit        = cur_used && (mem_rdata.key == key_ff);
   assign probe_done = hit || cur_empty || (&count_ff);
   assign tomb_any   = tomb_seen_ff || cur_tomb;
   assign tomb_at    = tomb_seen_ff ? tomb_idx_ff : rd_idx_ff;
   assign target     = (!hit && tomb_any) ? tomb_at : rd_idx_ff;
   assign fresh      = !hit && !tomb_any && cur_empty;
   assign none       = !hit && !tomb_any && !cur_empty;
   assign over       = fresh && (({1'b0, used_count_ff} + 10'd1) > {2'b00, load_limit});

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         oaht_pkg::ST_CLEAR: begin
            if (&clr_idx_ff) state_in = oaht_pkg::ST_IDLE;
         end
         oaht_pkg::ST_IDLE: begin
            if (accept && !early_miss) state_in = oaht_pkg::ST_PROBE;
         end
         oaht_pkg::ST_PROBE: begin
            if (probe_done) state_in = oaht_pkg::ST_IDLE;
         end
         default: begin
            state_in = oaht_pkg::ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      mem_we        = 1'b0;
      mem_waddr     = target;
      mem_wdata     = '{kind: oaht_pkg::KIND_USED, key: key_ff, value: wval_ff};
      mem_raddr     = rd_idx_ff + AW'(1);
      clr_idx_in    = clr_idx_ff;
      count_in      = count_ff + AW'(1);
      tomb_seen_in  = tomb_seen_ff;
      tomb_idx_in   = tomb_idx_ff;
      used_count_in = used_count_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      wval_in       = wval_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = oaht_pkg::STATUS_MISS;
      rsp_new_in    = 1'b0;
      rsp_value_in  = 64'd0;
      unique case (state_ff)
         oaht_pkg::ST_CLEAR: begin
            mem_we     = 1'b1;
            mem_waddr  = clr_idx_ff;
            mem_wdata  = '{kind: oaht_pkg::KIND_EMPTY, key: 32'd0, value: 64'd0};
            clr_idx_in = clr_idx_ff + AW'(1);
         end
         oaht_pkg::ST_IDLE: begin
            mem_raddr    = req_key_hash[AW-1:0];
            count_in     = '0;
            tomb_seen_in = 1'b0;
            if (accept) begin
               op_in        = req_op;
               key_in       = req_key_id;
               wval_in      = req_write_value;
               rsp_valid_in = early_miss;
            end
         end
         oaht_pkg::ST_PROBE: begin
            if (cur_tomb && !tomb_seen_ff) begin
               tomb_seen_in = 1'b1;
               tomb_idx_in  = rd_idx_ff;
            end
            if (probe_done) begin
               rsp_valid_in = 1'b1;
               priority if (op_ff == oaht_pkg::OP_GET) begin
                  if (hit) begin
                     rsp_status_in = oaht_pkg::STATUS_OK;
                     rsp_value_in  = mem_rdata.value;
                  end
               end else if (op_ff == oaht_pkg::OP_DELETE) begin
                  if (hit) begin
                     rsp_status_in  = oaht_pkg::STATUS_OK;
                     mem_we         = 1'b1;
                     mem_wdata.kind = oaht_pkg::KIND_TOMB;
                  end
               end else begin
                  if (none || over) begin
                     rsp_status_in = oaht_pkg::STATUS_FULL;
                  end else begin
                     rsp_status_in = oaht_pkg::STATUS_OK;
                     rsp_new_in    = !hit;
                     mem_we        = 1'b1;
                     if (fresh) used_count_in = used_count_ff + 9'd1;
                  end
               end
            end
         end
         default: begin
            clr_idx_in = '0;
         end
      endcase
   end

   assign rd_idx_in = mem_raddr;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= oaht_pkg::ST_CLEAR;
         clr_idx_ff    <= '0;
         used_count_ff <= 9'd0;
         tomb_seen_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_idx_ff    <= clr_idx_in;
         used_count_ff <= used_count_in;
         tomb_seen_ff  <= tomb_seen_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff     <= rd_idx_in;
      count_ff      <= count_in;
      tomb_idx_ff   <= tomb_idx_in;
      op_ff         <= op_in;
      key_ff        <= key_in;
      wval_ff       <= wval_in;
      rsp_status_ff <= rsp_status_in;
      rsp_new_ff    <= rsp_new_in;
      rsp_value_ff  <= rsp_value_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_is_new_key = rsp_new_ff;
   assign rsp_read_value = rsp_value_ff;

   `ASSERT_NEXT(a_accept_probes, clock, reset, accept && !early_miss, state_ff == oaht_pkg::ST_PROBE, "probing request did not enter probe")
   `ASSERT_IMPLIES(a_idle_no_write, clock, reset, state_ff == oaht_pkg::ST_IDLE, !mem_we, "slot write while idle")
   `ASSERT_IMPLIES(a_full_no_write, clock, reset, rsp_valid_in && (rsp_status_in == oaht_pkg::STATUS_FULL), !mem_we, "refused set wrote a slot")
   `ASSERT_IMPLIES(a_rsp_when_idle, clock, reset, rsp_valid_ff, state_ff == oaht_pkg::ST_IDLE, "result beat while not idle")

endmodule

// ===== rtl/core/open_addressing_hash_table_top.sv =====
// Linear-probing hash table with tombstones. After reset the table runs a
// clearing pass over all TABLE_SLOTS slots with busy high. A request (get,
// set, delete) is taken when start is high and busy is low; a request holds
// busy while it probes its slots, and its result beat appears on the rsp_
// ports, marked by rsp_valid for one cycle, in the cycle busy falls, so the
// next request can start in that cycle. The slot memory reads one slot per
// cycle. A get or delete before any set has succeeded since reset, or an
// unknown op, answers in the next cycle without probing. Results cannot be
// stalled: capture each beat in the cycle rsp_valid is high.
module open_addressing_hash_table_top #(
   parameter int TABLE_SLOTS = oaht_pkg::DEF_TABLE_SLOTS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_op,
   input  logic [31:0] req_key_id,
   input  logic [31:0] req_key_hash,
   input  logic [63:0] req_write_value,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic        rsp_is_new_key,
   output logic [63:0] rsp_read_value,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int AW = $clog2(TABLE_SLOTS);

   logic               mem_we;
   logic [AW-1:0]      mem_waddr;
   logic [AW-1:0]      mem_raddr;
   oaht_pkg::slot_type mem_wdata;
   oaht_pkg::slot_type mem_rdata;
   logic [7:0]         load_limit;

   oaht_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready),
      .load_limit (load_limit)
   );

   oaht_slot_ram #(
      .TABLE_SLOTS (TABLE_SLOTS)
   ) u_slot_ram (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   oaht_probe #(
      .TABLE_SLOTS (TABLE_SLOTS)
   ) u_probe (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_op          (req_op),
      .req_key_id      (req_key_id),
      .req_key_hash    (req_key_hash),
      .req_write_value (req_write_value),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_is_new_key  (rsp_is_new_key),
      .rsp_read_value  (rsp_read_value),
      .load_limit      (load_limit),
      .mem_we          (mem_we),
      .mem_waddr       (mem_waddr),
      .mem_wdata       (mem_wdata),
      .mem_raddr       (mem_raddr),
      .mem_rdata       (mem_rdata)
   );

endmodule

// ===== tb/testbench.sv =====
module testbench;

   localparam int TABLE_SLOTS = oaht_pkg::DEF_TABLE_SLOTS;
   localparam int POOL_KEYS = 40;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int DRAIN_CYCLES = 300;
   localparam int REPORT_LIMIT = 10;
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam logic [2:0] LOAD_LIMIT_ADDR = {oaht_pkg::CSR_IDX_LOAD_LIMIT, 2'b00};

   typedef enum logic [1:0] {
      PROBE_HIT,
      PROBE_TOMB,
      PROBE_EMPTY,
      PROBE_NONE
   } probe_end_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        is_new;
      logic [63:0] value;
   } table_reply_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_op = oaht_pkg::OP_GET;
   logic [31:0] req_key_id = '0;
   logic [31:0] req_key_hash = '0;
   logic [63:0] req_write_value = '0;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic        rsp_is_new_key;
   logic [63:0] rsp_read_value;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   logic [31:0] model_key [TABLE_SLOTS];
   logic [63:0] model_value [TABLE_SLOTS];
   logic [1:0]  model_kind [TABLE_SLOTS];
   logic [8:0]  model_used;
   logic [7:0]  model_limit;

   logic [31:0] pool_key [POOL_KEYS];
   logic [31:0] pool_hash [POOL_KEYS];

   table_reply_type expected_replies[$];
   int mismatches = 0;
   int stalled_cycles = 0;
   int sender_idle_pct = 11;

   open_addressing_hash_table_top uut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_op(req_op),
      .req_key_id(req_key_id),
      .req_key_hash(req_key_hash),
      .req_write_value(req_write_value),
      .rsp_valid(rsp_valid),
      .rsp_status(rsp_status),
      .rsp_is_new_key(rsp_is_new_key),
      .rsp_read_value(rsp_read_value),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   always #6 clock = ~clock;

   function automatic probe_end_type find_slot(input logic [31:0] key,
                                               input logic [31:0] hash,
                                               output int unsigned slot);
      int unsigned idx;
      int unsigned tomb;
      bit have_tomb;
      idx = hash & (TABLE_SLOTS - 1);
      tomb = 0;
      have_tomb = 1'b0;
      slot = 0;
      for (int n = 0; n < TABLE_SLOTS; n++) begin
         if (model_kind[idx] == oaht_pkg::KIND_USED) begin
            if (model_key[idx] == key) begin
               slot = idx;
               return PROBE_HIT;
            end
         end else if (model_kind[idx] == oaht_pkg::KIND_TOMB) begin
            if (!have_tomb) begin
               have_tomb = 1'b1;
               tomb = idx;
            end
         end else begin
            slot = have_tomb ? tomb : idx;
            return have_tomb ? PROBE_TOMB : PROBE_EMPTY;
         end
         idx = (idx + 1) & (TABLE_SLOTS - 1);
      end
      slot = tomb;
      return have_tomb ? PROBE_TOMB : PROBE_NONE;
   endfunction

   function automatic table_reply_type serve_request(input logic [1:0] op,
                                                     input logic [31:0] key,
                                                     input logic [31:0] hash,
                                                     input logic [63:0] wval);
      table_reply_type reply;
      probe_end_type found;
      int unsigned slot;
      reply.status = oaht_pkg::STATUS_MISS;
      reply.is_new = 1'b0;
      reply.value = '0;
      if (op == oaht_pkg::OP_GET || op == oaht_pkg::OP_DELETE) begin
         if (model_used != 0) begin
            found = find_slot(key, hash, slot);
            if (found == PROBE_HIT) begin
               reply.status = oaht_pkg::STATUS_OK;
               if (op == oaht_pkg::OP_GET) begin
                  reply.value = model_value[slot];
               end else begin
                  model_kind[slot] = oaht_pkg::KIND_TOMB;
               end
            end
         end
      end else if (op == oaht_pkg::OP_SET) begin
         found = find_slot(key, hash, slot);
         if (found == PROBE_NONE ||
             (found == PROBE_EMPTY && model_used + 9'd1 > {1'b0, model_limit})) begin
            reply.status = oaht_pkg::STATUS_FULL;
         end else begin
            if (found == PROBE_EMPTY) begin
               model_used = model_used + 9'd1;
            end
            reply.is_new = (found != PROBE_HIT);
            model_kind[slot] = oaht_pkg::KIND_USED;
            model_key[slot] = key;
            model_value[slot] = wval;
            reply.status = oaht_pkg::STATUS_OK;
         end
      end
      return reply;
   endfunction

   function automatic logic [31:0] clustered_hash();
      logic [31:0] hash;
      hash = $urandom;
      case ($urandom_range(0, 3))
         0: hash[7:0] = 8'h00 + 8'($urandom_range(0, 7));
         1: hash[7:0] = 8'h40 + 8'($urandom_range(0, 15));
         2: hash[7:0] = 8'hF8 + 8'($urandom_range(0, 7));
         default: hash[7:0] = 8'($urandom);
      endcase
      return hash;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] want,
                                  input logic [63:0] got);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) begin
         $display("mismatch %0d: %s expected %h got %h", mismatches, what, want, got);
      end
   endtask

   always @(posedge clock) begin
      table_reply_type want;
      if (rsp_valid) begin
         if (expected_replies.size() == 0) begin
            report_mismatch("unexpected beat, rsp_status", '0, 64'(rsp_status));
         end else begin
            want = expected_replies.pop_front();
            if (rsp_status !== want.status)
               report_mismatch("rsp_status", 64'(want.status), 64'(rsp_status));
            if (rsp_is_new_key !== want.is_new)
               report_mismatch("rsp_is_new_key", 64'(want.is_new), 64'(rsp_is_new_key));
            if (rsp_read_value !== want.value)
               report_mismatch("rsp_read_value", want.value, rsp_read_value);
         end
      end
   end

   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid || (psel && penable)) begin
         stalled_cycles <= 0;
      end else begin
         stalled_cycles <= stalled_cycles + 1;
      end
      if (stalled_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   task automatic issue_request(input logic [1:0] op, input logic [31:0] key,
                                input logic [31:0] hash, input logic [63:0] wval);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_op <= op;
      req_key_id <= key;
      req_key_hash <= hash;
      req_write_value <= wval;
      do @(posedge clock); while (busy);
      expected_replies.push_back(serve_request(op, key, hash, wval));
   endtask

   task automatic wait_until_idle();
      start <= 1'b0;
      do @(posedge clock); while (expected_replies.size() != 0 || busy);
      repeat (2) @(posedge clock);
   endtask

   task automatic check_load_limit(input logic [7:0] want);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= LOAD_LIMIT_ADDR;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata[7:0] !== want)
         report_mismatch("load_limit readback", 64'(want), 64'(prdata[7:0]));
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic program_load_limit(input logic [7:0] limit);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= LOAD_LIMIT_ADDR;
      pwdata <= {24'd0, limit};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      model_limit = limit;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
      check_load_limit(limit);
   endtask

   task automatic random_request();
      int pick;
      int entry;
      logic [1:0] op;
      logic [31:0] key;
      logic [31:0] hash;
      logic [63:0] wval;
      pick = $urandom_range(0, 99);
      entry = $urandom_range(0, POOL_KEYS - 1);
      wval = {$urandom, $urandom};
      if (pick < 8) begin
         op = 2'($urandom_range(0, 3));
         key = $urandom;
         hash = $urandom;
      end else if (pick < 35) begin
         pool_key[entry] = $urandom;
         pool_hash[entry] = clustered_hash();
         op = oaht_pkg::OP_SET;
         key = pool_key[entry];
         hash = pool_hash[entry];
      end else begin
         key = pool_key[entry];
         hash = pool_hash[entry];
         pick = $urandom_range(0, 99);
         if (pick < 35) op = oaht_pkg::OP_GET;
         else if (pick < 75) op = oaht_pkg::OP_SET;
         else if (pick < 96) op = oaht_pkg::OP_DELETE;
         else op = OP_UNUSED;
      end
      issue_request(op, key, hash, wval);
   endtask

   task automatic test_empty_table();
      wait_until_idle();
      check_load_limit(oaht_pkg::LOAD_LIMIT_RESET);
      issue_request(oaht_pkg::OP_GET, 32'h0000_0011, 32'h0000_0003, '0);
      issue_request(oaht_pkg::OP_DELETE, 32'h0000_0011, 32'h0000_0003, '1);
   endtask

   task automatic test_load_limit_floor();
      wait_until_idle();
      program_load_limit(8'd1);
      issue_request(oaht_pkg::OP_SET, 32'h0000_0000, 32'hFFFF_FFFF, '1);
      issue_request(oaht_pkg::OP_SET, 32'h0000_0011, 32'hFFFF_FFFF, 64'h1234_5678_9ABC_DEF0);
      issue_request(oaht_pkg::OP_SET, 32'h0000_0000, 32'hFFFF_FFFF, '0);
      issue_request(oaht_pkg::OP_GET, 32'h0000_0000, 32'hFFFF_FFFF, '1);
      issue_request(OP_UNUSED, '1, '1, '1);
      issue_request(oaht_pkg::OP_DELETE, 32'h0000_0000, 32'hFFFF_FFFF, '0);
      issue_request(oaht_pkg::OP_GET, 32'h0000_0000, 32'hFFFF_FFFF, '0);
      issue_request(oaht_pkg::OP_SET, 32'h0000_0011, 32'hFFFF_FFFF, 64'hFEDC_BA98_7654_3210);
      issue_request(oaht_pkg::OP_GET, 32'h0000_0011, 32'h0000_00FF, '0);
      issue_request(oaht_pkg::OP_DELETE, 32'h0000_0011, 32'h0000_0000, '0);
   endtask

   task automatic test_wrap_and_extremes();
      wait_until_idle();
      program_load_limit(8'd255);
      issue_request(oaht_pkg::OP_SET, 32'h0000_0022, 32'h1234_56FF, 64'h8000_0000_0000_0001);
      issue_request(oaht_pkg::OP_GET, 32'h0000_0022, 32'h1234_56FF, '0);
      issue_request(oaht_pkg::OP_SET, 32'hFFFF_FFFF, 32'h8000_0000, '0);
      issue_request(oaht_pkg::OP_GET, 32'hFFFF_FFFF, 32'h8000_0000, '1);
      issue_request(oaht_pkg::OP_DELETE, 32'h0000_0022, 32'hFFFF_FFFF, '0);
      issue_request(oaht_pkg::OP_GET, 32'h0000_0022, 32'h0000_00FF, '0);
      issue_request(oaht_pkg::OP_SET, 32'h0000_0022, 32'h0000_00FF, 64'h7FFF_FFFF_FFFF_FFFE);
      issue_request(oaht_pkg::OP_GET, 32'h0000_0022, 32'h0000_00FF, '0);
      issue_request(OP_UNUSED, '0, '0, '0);
      issue_request(oaht_pkg::OP_DELETE, 32'hFFFF_FFFF, 32'h8000_0000, '1);
   endtask

   task automatic test_mixed_traffic(input logic [7:0] limit, input int idle_pct,
                                     input int count);
      wait_until_idle();
      program_load_limit(limit);
      sender_idle_pct = idle_pct;
      repeat (count) random_request();
   endtask

   initial begin
      for (int i = 0; i < TABLE_SLOTS; i++) begin
         model_kind[i] = oaht_pkg::KIND_EMPTY;
         model_key[i] = '0;
         model_value[i] = '0;
      end
      model_used = '0;
      model_limit = oaht_pkg::LOAD_LIMIT_RESET;
      for (int i = 0; i < POOL_KEYS; i++) begin
         pool_key[i] = $urandom;
         pool_hash[i] = clustered_hash();
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_empty_table();
      test_load_limit_floor();
      test_wrap_and_extremes();
      test_mixed_traffic(8'd64, 11, 315);
      test_mixed_traffic(8'd128, 74, 315);
      test_mixed_traffic(8'd255, 0, 315);

      wait_until_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_replies.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/oaht_pkg.sv
rtl/core/oaht_slot_ram.sv
rtl/core/oaht_csr.sv
rtl/core/oaht_probe.sv
rtl/core/open_addressing_hash_table_top.sv
tb/testbench.sv
